// ----- hw/rtl/mlm_pkg.sv -----
package mlm_pkg;

    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 512;
    localparam int LABEL_BITS_DEF = 16;

    localparam int LBL_FIELD_BITS = 16;
    localparam int FRAME_BITS     = 10;
    localparam int RADIUS_BITS    = 11;
    localparam int DIST_BITS      = 11;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CMDQ_DEPTH     = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MODE   = 3'd0,
        REG_TARGET = 3'd1,
        REG_RADIUS = 3'd2,
        REG_WIDTH  = 3'd3,
        REG_HEIGHT = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef enum logic {
        MODE_DILATE = 1'b0,
        MODE_ERODE  = 1'b1
    } mode_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } cmd_status_t;

endpackage

// ----- hw/rtl/manhattan_label_morphology.sv -----
// Channel   Direction  Handshake             Beat
// input     in         push / full           kind, label
// result    out        empty / pop           out_label, last, not_ready
// config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// Load: ST_IDLE then ST_LD_WR; read: not_ready from ST_IDLE or a label RAM
// read in ST_RD_OUT. The final load starts the backward pass, ST_BK_BELOW,
// ST_BK_SELF, ST_BK_CALC per pixel, as the distance RAM has one read port.
// A width write mid-frame has ST_DIV recover the column before the next load.
// Reset clears control, sets config defaults; RAM and data stay undefined.
// A two-beat command queue and one result register decouple the two sides.
module manhattan_label_morphology #(
    parameter int MAX_WIDTH  = mlm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mlm_pkg::MAX_HEIGHT_DEF,
    parameter int LABEL_BITS = mlm_pkg::LABEL_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic                                kind,
    input  logic [LABEL_BITS-1:0]               label,
    output logic                                empty,
    input  logic                                pop,
    output logic [LABEL_BITS-1:0]               out_label,
    output logic                                last,
    output logic                                not_ready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mlm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [mlm_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import mlm_pkg::*;

    cmd_status_t           cmd_status;
    logic [LABEL_BITS-1:0] cmd_label;
    logic                  cmd_pop;

    assign cfg_ready = 1'b1;

    mlm_front #(
        .LABEL_BITS (LABEL_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .kind       (kind),
        .label      (label),
        .cmd_status (cmd_status),
        .cmd_label  (cmd_label),
        .cmd_pop    (cmd_pop)
    );

    mlm_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .LABEL_BITS (LABEL_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd_status (cmd_status),
        .cmd_label  (cmd_label),
        .cmd_pop    (cmd_pop),
        .empty      (empty),
        .pop        (pop),
        .out_label  (out_label),
        .last       (last),
        .not_ready  (not_ready)
    );

endmodule

// ----- hw/rtl/mlm_ram.sv -----
module mlm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/mlm_front.sv -----
module mlm_front #(
    parameter int LABEL_BITS = mlm_pkg::LABEL_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic                      kind,
    input  logic [LABEL_BITS-1:0]     label,
    output mlm_pkg::cmd_status_t      cmd_status,
    output logic [LABEL_BITS-1:0]     cmd_label,
    input  logic                      cmd_pop
);
    import mlm_pkg::*;

    localparam int PTR_BITS = $clog2(CMDQ_DEPTH);
    localparam int CNT_BITS = $clog2(CMDQ_DEPTH + 1);

    op_t                   op_q    [CMDQ_DEPTH];
    logic [LABEL_BITS-1:0] label_q [CMDQ_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic                  do_push, do_pop;
    logic [LABEL_BITS-1:0] label_in;

    assign full     = (count_reg == CNT_BITS'(CMDQ_DEPTH));
    assign do_push  = push && !full;
    assign do_pop   = cmd_pop && (count_reg != '0);
    assign label_in = LABEL_BITS'(LBL_FIELD_BITS'(label));

    assign cmd_status.valid = (count_reg != '0);
    assign cmd_status.op    = op_q[rd_ptr_reg];
    assign cmd_label        = label_q[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            op_q[wr_ptr_reg]    <= kind ? OP_READ : OP_LOAD;
            label_q[wr_ptr_reg] <= label_in;
        end
    end

endmodule

// ----- hw/rtl/mlm_back.sv -----
module mlm_back #(
    parameter int MAX_WIDTH  = mlm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mlm_pkg::MAX_HEIGHT_DEF,
    parameter int LABEL_BITS = mlm_pkg::LABEL_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mlm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [mlm_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  mlm_pkg::cmd_status_t                cmd_status,
    input  logic [LABEL_BITS-1:0]               cmd_label,
    output logic                                cmd_pop,
    output logic                                empty,
    input  logic                                pop,
    output logic [LABEL_BITS-1:0]               out_label,
    output logic                                last,
    output logic                                not_ready
);
    import mlm_pkg::*;

    localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int DIV_BITS  = $clog2(CNT_BITS + 1);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_DIV      = 9'b000000010,
        ST_LD_WR    = 9'b000000100,
        ST_BK_BELOW = 9'b000001000,
        ST_BK_SELF  = 9'b000010000,
        ST_BK_CALC  = 9'b000100000,
        ST_RD_OUT   = 9'b001000000,
        ST_RSV0     = 9'b010000000,
        ST_RSV1     = 9'b100000000
    } state_t;

    function automatic logic [DIST_BITS-1:0] min_inc(input logic [DIST_BITS-1:0] d,
                                                      input logic [DIST_BITS-1:0] n);
        logic [DIST_BITS:0] c;
        c = {1'b0, n} + 1'b1;
        min_inc = (c < {1'b0, d}) ? c[DIST_BITS-1:0] : d;
    endfunction

    state_t                   state_reg, state_next;
    logic                     mode_reg;
    logic [CFG_DATA_BITS-1:0] target_reg;
    logic [RADIUS_BITS-1:0]   radius_reg;
    logic [FRAME_BITS-1:0]    fw_reg, fh_reg;
    logic [FRAME_BITS-1:0]    w_eff, h_eff;
    logic [CNT_BITS-1:0]      total_reg, total_next;

    logic [CNT_BITS-1:0]      load_count_reg, load_count_next;
    logic [CNT_BITS-1:0]      rp_reg, rp_next;
    logic                     fc_reg, fc_next;
    logic [FRAME_BITS-1:0]    col_reg, col_next;
    logic                     dirty_reg, dirty_next;

    logic [LABEL_BITS-1:0]    lab_reg, lab_next;
    logic [ADDR_BITS-1:0]     p_reg, p_next;
    logic                     seed_reg, seed_next;
    logic                     gew_reg, gew_next;
    logic [DIST_BITS-1:0]     prev_d_reg, prev_d_next;
    logic [DIST_BITS-1:0]     below_reg, below_next;
    logic [FRAME_BITS-1:0]    bx_reg, bx_next;
    logic [FRAME_BITS-1:0]    by_reg, by_next;

    logic [FRAME_BITS:0]      rem_reg, rem_next;
    logic [CNT_BITS-1:0]      src_reg, src_next;
    logic [DIV_BITS-1:0]      dcnt_reg, dcnt_next;

    logic                     ov_reg, ov_next;
    logic [LABEL_BITS-1:0]    ol_reg, ol_next;
    logic                     olast_reg, olast_next;
    logic                     onr_reg, onr_next;

    logic [ADDR_BITS-1:0]     d_raddr, d_waddr;
    logic                     d_we;
    logic [DIST_BITS-1:0]     d_wdata, d_rdata;
    logic                     l_we;
    logic [LABEL_BITS-1:0]    l_wdata, l_rdata;

    logic [LABEL_BITS-1:0]    tgt;
    logic [CNT_BITS-1:0]      p_eff;
    logic [DIST_BITS-1:0]     d_calc;
    logic [FRAME_BITS:0]      rem_t;
    logic                     in_reach;

    always_comb
    begin
        w_eff = fw_reg;
        if (fw_reg == '0)
        begin
            w_eff = FRAME_BITS'(1);
        end
        else if (32'(fw_reg) > MAX_WIDTH)
        begin
            w_eff = FRAME_BITS'(MAX_WIDTH);
        end
        h_eff = fh_reg;
        if (fh_reg == '0)
        begin
            h_eff = FRAME_BITS'(1);
        end
        else if (32'(fh_reg) > MAX_HEIGHT)
        begin
            h_eff = FRAME_BITS'(MAX_HEIGHT);
        end
    end

    assign total_next = CNT_BITS'({{FRAME_BITS{1'b0}}, w_eff} * {{FRAME_BITS{1'b0}}, h_eff});
    assign tgt        = LABEL_BITS'(target_reg);
    assign p_eff      = fc_reg ? '0 : load_count_reg;
    assign rem_t      = {rem_reg[FRAME_BITS-1:0], src_reg[CNT_BITS-1]};
    assign in_reach   = (d_calc <= radius_reg);

    assign empty      = !ov_reg;
    assign out_label  = ol_reg;
    assign last       = olast_reg;
    assign not_ready  = onr_reg;

    always_comb
    begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        rp_next         = rp_reg;
        fc_next         = fc_reg;
        col_next        = col_reg;
        dirty_next      = dirty_reg;
        lab_next        = lab_reg;
        p_next          = p_reg;
        seed_next       = seed_reg;
        gew_next        = gew_reg;
        prev_d_next     = prev_d_reg;
        below_next      = below_reg;
        bx_next         = bx_reg;
        by_next         = by_reg;
        rem_next        = rem_reg;
        src_next        = src_reg;
        dcnt_next       = dcnt_reg;
        ov_next         = ov_reg && !pop;
        ol_next         = ol_reg;
        olast_next      = olast_reg;
        onr_next        = onr_reg;
        cmd_pop         = 1'b0;
        d_raddr         = p_reg;
        d_waddr         = p_reg;
        d_we            = 1'b0;
        d_wdata         = '0;
        l_we            = 1'b0;
        l_wdata         = lab_reg;
        d_calc          = d_rdata;

        if (cfg_we && (cfg_reg_t'(cfg_index) == REG_WIDTH))
        begin
            dirty_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_status.valid && (cmd_status.op == OP_LOAD))
                begin
                    if (!fc_reg && dirty_reg)
                    begin
                        src_next   = load_count_reg;
                        rem_next   = '0;
                        dcnt_next  = '0;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        cmd_pop   = 1'b1;
                        if (fc_reg)
                        begin
                            fc_next    = 1'b0;
                            rp_next    = '0;
                            col_next   = '0;
                            dirty_next = 1'b0;
                        end
                        lab_next  = cmd_label;
                        p_next    = p_eff[ADDR_BITS-1:0];
                        seed_next = (mode_reg == MODE_DILATE) ? (cmd_label == tgt)
                                                              : (cmd_label != tgt);
                        gew_next  = (p_eff >= CNT_BITS'(w_eff));
                        d_raddr   = p_eff[ADDR_BITS-1:0] - ADDR_BITS'(w_eff);
                        state_next = ST_LD_WR;
                    end
                end
                else if (cmd_status.valid && !ov_reg)
                begin
                    cmd_pop = 1'b1;
                    if (!fc_reg || (rp_reg >= total_reg))
                    begin
                        ov_next    = 1'b1;
                        ol_next    = '0;
                        olast_next = 1'b0;
                        onr_next   = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_RD_OUT;
                    end
                end
            end

            ST_DIV:
            begin
                rem_next  = (rem_t >= {1'b0, w_eff}) ? rem_t - {1'b0, w_eff} : rem_t;
                src_next  = src_reg << 1;
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DIV_BITS'(CNT_BITS - 1))
                begin
                    col_next   = rem_next[FRAME_BITS-1:0];
                    dirty_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end

            ST_LD_WR:
            begin
                if (seed_reg)
                begin
                    d_calc = '0;
                end
                else
                begin
                    d_calc = DIST_BITS'(w_eff) + DIST_BITS'(h_eff);
                    if (col_reg != '0)
                    begin
                        d_calc = min_inc(d_calc, prev_d_reg);
                    end
                    if (gew_reg)
                    begin
                        d_calc = min_inc(d_calc, d_rdata);
                    end
                end
                d_we            = 1'b1;
                d_wdata         = d_calc;
                l_we            = 1'b1;
                l_wdata         = lab_reg;
                prev_d_next     = d_calc;
                load_count_next = CNT_BITS'(p_reg) + 1'b1;
                col_next        = ({1'b0, col_reg} + 1'b1 >= {1'b0, w_eff}) ? '0
                                                                            : col_reg + 1'b1;
                if (load_count_next >= total_reg)
                begin
                    p_next     = ADDR_BITS'(total_reg - 1'b1);
                    bx_next    = w_eff - 1'b1;
                    by_next    = h_eff - 1'b1;
                    state_next = ST_BK_BELOW;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_BK_BELOW:
            begin
                d_raddr    = p_reg + ADDR_BITS'(w_eff);
                state_next = ST_BK_SELF;
            end

            ST_BK_SELF:
            begin
                below_next = d_rdata;
                d_raddr    = p_reg;
                state_next = ST_BK_CALC;
            end

            ST_BK_CALC:
            begin
                d_calc = d_rdata;
                if ({1'b0, bx_reg} + 1'b1 < {1'b0, w_eff})
                begin
                    d_calc = min_inc(d_calc, prev_d_reg);
                end
                if ({1'b0, by_reg} + 1'b1 < {1'b0, h_eff})
                begin
                    d_calc = min_inc(d_calc, below_reg);
                end
                d_we        = 1'b1;
                d_wdata     = d_calc;
                prev_d_next = d_calc;
                if (mode_reg == MODE_DILATE)
                begin
                    l_we    = in_reach;
                    l_wdata = tgt;
                end
                else
                begin
                    l_we    = 1'b1;
                    l_wdata = in_reach ? '0 : tgt;
                end
                if (p_reg == '0)
                begin
                    fc_next    = 1'b1;
                    rp_next    = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    p_next = p_reg - 1'b1;
                    if (bx_reg == '0)
                    begin
                        bx_next = w_eff - 1'b1;
                        by_next = by_reg - 1'b1;
                    end
                    else
                    begin
                        bx_next = bx_reg - 1'b1;
                    end
                    state_next = ST_BK_BELOW;
                end
            end

            ST_RD_OUT:
            begin
                ov_next    = 1'b1;
                ol_next    = l_rdata;
                olast_next = (rp_reg + 1'b1 == total_reg);
                onr_next   = 1'b0;
                rp_next    = rp_reg + 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MODE_DILATE;
            target_reg     <= CFG_DATA_BITS'(1);
            radius_reg     <= RADIUS_BITS'(1);
            fw_reg         <= FRAME_BITS'(512);
            fh_reg         <= FRAME_BITS'(512);
            total_reg      <= '0;
            load_count_reg <= '0;
            rp_reg         <= '0;
            fc_reg         <= 1'b0;
            col_reg        <= '0;
            dirty_reg      <= 1'b0;
            dcnt_reg       <= '0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            total_reg      <= total_next;
            load_count_reg <= load_count_next;
            rp_reg         <= rp_next;
            fc_reg         <= fc_next;
            col_reg        <= col_next;
            dirty_reg      <= dirty_next;
            dcnt_reg       <= dcnt_next;
            ov_reg         <= ov_next;
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_MODE:   mode_reg   <= cfg_data[0];
                    REG_TARGET: target_reg <= cfg_data;
                    REG_RADIUS: radius_reg <= cfg_data[RADIUS_BITS-1:0];
                    REG_WIDTH:  fw_reg     <= cfg_data[FRAME_BITS-1:0];
                    REG_HEIGHT: fh_reg     <= cfg_data[FRAME_BITS-1:0];
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lab_reg    <= lab_next;
        p_reg      <= p_next;
        seed_reg   <= seed_next;
        gew_reg    <= gew_next;
        prev_d_reg <= prev_d_next;
        below_reg  <= below_next;
        bx_reg     <= bx_next;
        by_reg     <= by_next;
        rem_reg    <= rem_next;
        src_reg    <= src_next;
        ol_reg     <= ol_next;
        olast_reg  <= olast_next;
        onr_reg    <= onr_next;
    end

    mlm_ram #(
        .WIDTH (DIST_BITS),
        .DEPTH (DEPTH)
    ) u_dist_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    mlm_ram #(
        .WIDTH (LABEL_BITS),
        .DEPTH (DEPTH)
    ) u_label_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (p_reg),
        .wdata (l_wdata),
        .raddr (rp_reg[ADDR_BITS-1:0]),
        .rdata (l_rdata)
    );

endmodule
